// File: rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types, token codes and keyword table of the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

  localparam int CHAR_W     = 8;
  localparam int TOKEN_W    = 6;
  localparam int VALUE_W    = 32;
  localparam int ERR_W      = 2;
  localparam int KW_NUM     = 32;
  localparam int KW_IDX_W   = 5;
  localparam int KW_MAX_LEN = 15;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_NAME,
    MODE_DEC,
    MODE_HEX,
    MODE_LT,
    MODE_PLUS,
    MODE_MINUS,
    MODE_HALT
  } mode_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_NAME,
    ERR_CHAR,
    ERR_COMMENT
  } err_e;

  localparam logic [TOKEN_W-1:0] TOK_DECVAL = 6'd32;
  localparam logic [TOKEN_W-1:0] TOK_HEXVAL = 6'd33;
  localparam logic [TOKEN_W-1:0] TOK_XFER   = 6'd34;
  localparam logic [TOKEN_W-1:0] TOK_INC    = 6'd35;
  localparam logic [TOKEN_W-1:0] TOK_PLUS   = 6'd36;
  localparam logic [TOKEN_W-1:0] TOK_DECR   = 6'd37;
  localparam logic [TOKEN_W-1:0] TOK_MINUS  = 6'd38;
  localparam logic [TOKEN_W-1:0] TOK_AND    = 6'd39;
  localparam logic [TOKEN_W-1:0] TOK_OR     = 6'd40;
  localparam logic [TOKEN_W-1:0] TOK_XOR    = 6'd41;
  localparam logic [TOKEN_W-1:0] TOK_LPAREN = 6'd42;
  localparam logic [TOKEN_W-1:0] TOK_RPAREN = 6'd43;
  localparam logic [TOKEN_W-1:0] TOK_SEMI   = 6'd44;
  localparam logic [TOKEN_W-1:0] TOK_COMMA  = 6'd45;
  localparam logic [TOKEN_W-1:0] TOK_BANG   = 6'd46;
  localparam logic [TOKEN_W-1:0] TOK_STAR   = 6'd47;
  localparam logic [TOKEN_W-1:0] TOK_END    = 6'd48;
  localparam logic [TOKEN_W-1:0] TOK_ERROR  = 6'd49;

  // keyword text, right-aligned
  localparam logic [KW_MAX_LEN*CHAR_W-1:0] KW_TEXT [KW_NUM] = '{
    "OP", "ENDOP", "A", "X", "Y", "MDR", "PC", "PPC", "DP", "SP", "USP",
    "MAR", "IR", "MSW", "IPTR", "SHR", "HI", "LO", "C", "Z", "N", "V",
    {"SETFLAGS_", "WORD"}, {"SETFLAGS_", "HIBYTE"}, {"SETFLAGS_", "LOBYTE"}, "MEM",
    "LATCH_I", "LATCH_S", "FETCH", "CODE", "DATA", "SUPERVISOR"
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd2, 4'd5, 4'd1, 4'd1, 4'd1, 4'd3, 4'd2, 4'd3, 4'd2, 4'd2, 4'd3,
    4'd3, 4'd2, 4'd3, 4'd4, 4'd3, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd13, 4'd15, 4'd15, 4'd3,
    4'd7, 4'd7, 4'd5, 4'd4, 4'd4, 4'd10
  };

  function automatic logic [CHAR_W-1:0] kw_byte(int idx, int pos);
    logic [CHAR_W-1:0] b;
    b = '0;
    if (pos < int'(KW_LEN[idx])) begin
      b = KW_TEXT[idx][CHAR_W*(int'(KW_LEN[idx]) - 1 - pos) +: CHAR_W];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mst_if.sv
// ----------------------------------------------------------------------------
// mst_if
// Valid/ready channels of the source tokenizer: byte in, token out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mst_in_if;
  import mst_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              at_end;

  modport source (output valid, char_in, at_end, input ready);
  modport sink   (input valid, char_in, at_end, output ready);
endinterface

interface mst_out_if #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 12
);
  import mst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TOKEN_W-1:0]     token_code;
  logic [VALUE_W-1:0]     number_value;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column_number;
  logic [ERR_W-1:0]       error_kind;
  logic                   last_of_run;

  modport source (output valid, token_code, number_value, line_number, column_number,
                  error_kind, last_of_run, input ready);
  modport sink   (input valid, token_code, number_value, line_number, column_number,
                  error_kind, last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/microcode_source_tokenizer.sv
// ----------------------------------------------------------------------------
// microcode_source_tokenizer
// Streaming tokenizer: one source byte per beat in, tokens out.
// ----------------------------------------------------------------------------
// Takes one byte (or end marker) per clock. The scanner state is updated in
// the same cycle and the finished tokens go into a four-entry result queue,
// so a byte is accepted whenever the queue has two free slots. A byte that
// completes two tokens fills two queue slots at once; with a ready sink
// and single-token bytes the sustained rate is one byte per cycle. After an
// ERROR token no further tokens are produced until reset.
`default_nettype none

module microcode_source_tokenizer #(
  parameter int MAX_NAME_LEN = 15,
  parameter int LINE_BITS    = 16,
  parameter int COLUMN_BITS  = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mst_in_if.sink     in_i,
  mst_out_if.source  out_o
);
  import mst_pkg::*;

  localparam int RES_W = TOKEN_W + VALUE_W + LINE_BITS + COLUMN_BITS + ERR_W + 1;

  logic             fire;
  logic             room;
  logic [1:0]       n_res;
  logic [RES_W-1:0] res0, res1, head;

  assign in_i.ready = room;
  assign fire       = in_i.valid && room;

  mst_scan #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .LINE_BITS    (LINE_BITS),
    .COLUMN_BITS  (COLUMN_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .char_i   (in_i.char_in),
    .at_end_i (in_i.at_end),
    .n_res_o  (n_res),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  mst_res_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (n_res),
    .push0_i  (res0),
    .push1_i  (res1),
    .room_o   (room),
    .pop_i    (out_o.ready),
    .valid_o  (out_o.valid),
    .data_o   (head)
  );

  assign {out_o.token_code, out_o.number_value, out_o.line_number, out_o.column_number,
          out_o.error_kind, out_o.last_of_run} = head;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.line_number != '0 && out_o.column_number != '0))
    else $error("token with zero line or column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.token_code == TOK_ERROR) |-> out_o.last_of_run)
    else $error("error token not last of its run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.token_code == TOK_ERROR) == (out_o.error_kind != ERR_NONE)))
    else $error("error kind does not match token code");

endmodule

`default_nettype wire

// File: rtl/mst_kw_match.sv
// ----------------------------------------------------------------------------
// mst_kw_match
// Compares the collected name against the keyword table in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_kw_match #(
  parameter int MAX_NAME_LEN = 15,
  parameter int LEN_W        = $clog2(MAX_NAME_LEN + 1)
) (
  input  logic [mst_pkg::CHAR_W-1:0]   name_i [MAX_NAME_LEN],
  input  logic [LEN_W-1:0]             len_i,
  input  logic                         long_i,
  output logic                         hit_o,
  output logic [mst_pkg::KW_IDX_W-1:0] code_o
);
  import mst_pkg::*;

  localparam int CMP_LEN = (MAX_NAME_LEN < KW_MAX_LEN) ? MAX_NAME_LEN : KW_MAX_LEN;

  always_comb begin
    logic eq;
    hit_o  = 1'b0;
    code_o = '0;
    for (int i = 0; i < KW_NUM; i++) begin
      eq = !long_i && (int'(len_i) == int'(KW_LEN[i]));
      for (int j = 0; j < CMP_LEN; j++) begin
        if (j < int'(KW_LEN[i]) && name_i[j] != kw_byte(i, j)) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        hit_o  = 1'b1;
        code_o = KW_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mst_scan.sv
// ----------------------------------------------------------------------------
// mst_scan
// Scanner state and per-byte next-state logic; yields up to two tokens a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_scan #(
  parameter int MAX_NAME_LEN = 15,
  parameter int LINE_BITS    = 16,
  parameter int COLUMN_BITS  = 12,
  parameter int RES_W        = mst_pkg::TOKEN_W + mst_pkg::VALUE_W + LINE_BITS
                               + COLUMN_BITS + mst_pkg::ERR_W + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [mst_pkg::CHAR_W-1:0] char_i,
  input  logic                       at_end_i,
  output logic [1:0]                 n_res_o,
  output logic [RES_W-1:0]           res0_o,
  output logic [RES_W-1:0]           res1_o
);
  import mst_pkg::*;

  localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  mode_e                  mode_q, mode_d;
  logic [CHAR_W-1:0]      name_q [MAX_NAME_LEN];
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   long_q, long_d;
  logic [VALUE_W-1:0]     lit_q, lit_d;
  logic                   hexseen_q, hexseen_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] colcnt_q, colcnt_d;
  logic [COLUMN_BITS-1:0] tokcol_q, tokcol_d;

  logic                   nm_we;
  logic [LEN_W-1:0]       nm_pos;
  logic [CHAR_W-1:0]      ch_up;
  logic                   kw_hit;
  logic [KW_IDX_W-1:0]    kw_code;

  logic                   is_alpha, is_digit, is_space, is_hex;
  logic [3:0]             hex_val;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [LINE_BITS-1:0]   line_inc;

  logic                   to_idle;
  logic                   p_emit, s_emit;
  logic [TOKEN_W-1:0]     p_code, s_code;
  logic [COLUMN_BITS-1:0] p_col, s_col;
  err_e                   p_ek, s_ek;

  mst_kw_match #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_kw (
    .name_i (name_q),
    .len_i  (len_q),
    .long_i (long_q),
    .hit_o  (kw_hit),
    .code_o (kw_code)
  );

  assign is_alpha = (char_i >= "A" && char_i <= "Z") || (char_i >= "a" && char_i <= "z");
  assign is_digit = char_i >= "0" && char_i <= "9";
  assign is_space = char_i == " " || (char_i >= "\t" && char_i <= "\r");
  assign is_hex   = is_digit || (char_i >= "a" && char_i <= "f")
                    || (char_i >= "A" && char_i <= "F");
  assign hex_val  = is_digit ? char_i[3:0] : char_i[3:0] + 4'd9;
  assign ch_up    = (char_i >= "a" && char_i <= "z") ? char_i - CHAR_W'(32) : char_i;
  assign col_inc  = (colcnt_q == COL_MAX) ? colcnt_q : colcnt_q + COLUMN_BITS'(1);
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_BITS'(1);

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    long_d    = long_q;
    lit_d     = lit_q;
    hexseen_d = hexseen_q;
    line_d    = line_q;
    colcnt_d  = colcnt_q;
    tokcol_d  = tokcol_q;
    nm_we     = 1'b0;
    nm_pos    = len_q;
    to_idle   = 1'b0;
    p_emit    = 1'b0;
    p_code    = TOK_END;
    p_col     = tokcol_q;
    p_ek      = ERR_NONE;
    s_emit    = 1'b0;
    s_code    = TOK_END;
    s_col     = col_inc;
    s_ek      = ERR_NONE;

    if (mode_q != MODE_HALT && !at_end_i) begin
      colcnt_d = col_inc;
    end

    unique case (mode_q)
      MODE_HALT: begin
      end
      MODE_SLASH: begin
        if (!at_end_i && char_i == "/") begin
          mode_d = MODE_COMMENT;
        end else begin
          p_emit = 1'b1;
          p_code = TOK_ERROR;
          p_ek   = ERR_COMMENT;
          mode_d = MODE_HALT;
        end
      end
      MODE_COMMENT: begin
        if (at_end_i) begin
          p_emit = 1'b1;
          p_code = TOK_END;
          p_col  = col_inc;
        end else if (char_i == "\n") begin
          line_d   = line_inc;
          colcnt_d = '0;
          mode_d   = MODE_IDLE;
        end
      end
      MODE_LT: begin
        p_emit = 1'b1;
        if (!at_end_i && char_i == "-") begin
          p_code = TOK_XFER;
          mode_d = MODE_IDLE;
        end else begin
          p_code = TOK_ERROR;
          p_ek   = ERR_CHAR;
          mode_d = MODE_HALT;
        end
      end
      MODE_PLUS: begin
        p_emit = 1'b1;
        if (!at_end_i && char_i == "+") begin
          p_code = TOK_INC;
          mode_d = MODE_IDLE;
        end else begin
          p_code  = TOK_PLUS;
          to_idle = 1'b1;
        end
      end
      MODE_MINUS: begin
        p_emit = 1'b1;
        if (!at_end_i && char_i == "-") begin
          p_code = TOK_DECR;
          mode_d = MODE_IDLE;
        end else begin
          p_code  = TOK_MINUS;
          to_idle = 1'b1;
        end
      end
      MODE_NAME: begin
        if (!at_end_i && (is_alpha || char_i == "_")) begin
          if (int'(len_q) < MAX_NAME_LEN) begin
            nm_we = 1'b1;
            len_d = len_q + LEN_W'(1);
          end else begin
            long_d = 1'b1;
          end
        end else begin
          p_emit = 1'b1;
          if (kw_hit) begin
            p_code  = TOKEN_W'(kw_code);
            to_idle = 1'b1;
          end else begin
            p_code = TOK_ERROR;
            p_ek   = ERR_NAME;
            mode_d = MODE_HALT;
          end
        end
      end
      MODE_DEC: begin
        if (!at_end_i && is_digit) begin
          lit_d = (lit_q << 3) + (lit_q << 1) + {(VALUE_W-4)'(0), char_i[3:0]};
        end else begin
          p_emit  = 1'b1;
          p_code  = TOK_DECVAL;
          to_idle = 1'b1;
        end
      end
      MODE_HEX: begin
        if (!at_end_i && is_hex) begin
          lit_d     = hexseen_q ? {lit_q[VALUE_W-5:0], hex_val}
                                : {(VALUE_W-4)'(0), hex_val};
          hexseen_d = 1'b1;
        end else begin
          p_emit  = 1'b1;
          p_code  = TOK_HEXVAL;
          to_idle = 1'b1;
        end
      end
      default: begin
        to_idle = 1'b1;
      end
    endcase

    if (to_idle) begin
      mode_d = MODE_IDLE;
      if (at_end_i) begin
        s_emit = 1'b1;
        s_code = TOK_END;
      end else begin
        tokcol_d = col_inc;
        s_col    = col_inc;
        if (char_i == "\n") begin
          line_d   = line_inc;
          colcnt_d = '0;
        end else if (is_space) begin
        end else if (char_i == "/") begin
          mode_d = MODE_SLASH;
        end else if (is_alpha) begin
          nm_we  = 1'b1;
          nm_pos = '0;
          len_d  = LEN_W'(1);
          long_d = 1'b0;
          mode_d = MODE_NAME;
        end else if (is_digit) begin
          lit_d  = {(VALUE_W-4)'(0), char_i[3:0]};
          mode_d = MODE_DEC;
        end else if (char_i == "$") begin
          hexseen_d = 1'b0;
          mode_d    = MODE_HEX;
        end else if (char_i == "<") begin
          mode_d = MODE_LT;
        end else if (char_i == "+") begin
          mode_d = MODE_PLUS;
        end else if (char_i == "-") begin
          mode_d = MODE_MINUS;
        end else begin
          s_emit = 1'b1;
          case (char_i)
            "&":     s_code = TOK_AND;
            "|":     s_code = TOK_OR;
            "^":     s_code = TOK_XOR;
            "(":     s_code = TOK_LPAREN;
            ")":     s_code = TOK_RPAREN;
            ";":     s_code = TOK_SEMI;
            ",":     s_code = TOK_COMMA;
            "!":     s_code = TOK_BANG;
            "*":     s_code = TOK_STAR;
            default: begin
              s_code = TOK_ERROR;
              s_ek   = ERR_CHAR;
              mode_d = MODE_HALT;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    n_res_o = '0;
    res0_o  = {s_code, lit_q, line_q, s_col, s_ek, 1'b1};
    res1_o  = {s_code, lit_q, line_q, s_col, s_ek, 1'b1};
    if (p_emit) begin
      res0_o = {p_code, lit_q, line_q, p_col, p_ek, !s_emit};
    end
    if (fire_i) begin
      n_res_o = 2'(p_emit) + 2'(s_emit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      len_q     <= '0;
      long_q    <= 1'b0;
      lit_q     <= '0;
      hexseen_q <= 1'b0;
      line_q    <= LINE_BITS'(1);
      colcnt_q  <= '0;
      tokcol_q  <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      len_q     <= len_d;
      long_q    <= long_d;
      lit_q     <= lit_d;
      hexseen_q <= hexseen_d;
      line_q    <= line_d;
      colcnt_q  <= colcnt_d;
      tokcol_q  <= tokcol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_NAME_LEN; k++) begin
      if (fire_i && nm_we && nm_pos == LEN_W'(k)) begin
        name_q[k] <= ch_up;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mst_res_fifo.sv
// ----------------------------------------------------------------------------
// mst_res_fifo
// Four-entry token queue; takes up to two tokens a beat, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_res_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  logic [WIDTH-1:0] push0_i,
  input  logic [WIDTH-1:0] push1_i,
  output logic             room_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_nx;
  logic [CNT_W-1:0] cnt_q;
  logic             pop_fire;

  assign room_o   = cnt_q <= CNT_W'(DEPTH - 2);
  assign valid_o  = cnt_q != '0;
  assign data_o   = mem_q[rd_q];
  assign pop_fire = pop_i && valid_o;
  assign wr_nx    = wr_q + PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_n_i);
      rd_q  <= rd_q + PTR_W'(pop_fire);
      cnt_q <= cnt_q + CNT_W'(push_n_i) - CNT_W'(pop_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nx] <= push1_i;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_microcode_source_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_microcode_source_tokenizer
// Self-checking testbench for the streaming source tokenizer.
// ----------------------------------------------------------------------------
// A short table of bytes is walked first. Its first rows carry hand-written
// tokens and the rest are scored by a behavioural token model. Random source
// text follows: keywords in mixed case, decimal and hex literals, operators
// and comments, with end markers between lexemes and inside comments. The
// text is split into four phases of sender gaps and sink stalls. The run
// closes with one randomly chosen error and a burst of bytes that must
// yield nothing. Every output beat is compared field by field in order.
module tb_microcode_source_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import mst_pkg::*;

  localparam int          LIMIT_CYCLES    = 2_000_000;
  localparam int          DRAIN_CYCLES    = 32;
  localparam int          DRAIN_LIMIT     = 20_000;
  localparam int          BEATS_PER_PHASE = 460;
  localparam int          MAX_NAME        = 15;
  localparam int          N_DIR           = 30;
  localparam logic [15:0] LINE_TOP        = 16'hFFFF;
  localparam logic [11:0] COL_TOP         = 12'hFFF;
  localparam logic [7:0]  NL              = 8'h0A;

  typedef struct packed {
    logic [TOKEN_W-1:0] code;
    logic [VALUE_W-1:0] value;
    logic [15:0]        line;
    logic [11:0]        col;
    err_e               err;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
    logic       typed;
    token_t     want;
  } dir_row_t;

  typedef enum {LX_NAME, LX_DEC, LX_HEX, LX_PUNCT, LX_COMMENT} lex_e;

  logic clk_i;
  logic rst_ni;

  mst_in_if in_bus ();
  mst_out_if #(.LINE_BITS(16), .COLUMN_BITS(12)) out_bus ();

  microcode_source_tokenizer #(
    .MAX_NAME_LEN(15),
    .LINE_BITS   (16),
    .COLUMN_BITS (12)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  string kw_names [KW_NUM] = '{
    "OP", "ENDOP", "A", "X", "Y", "MDR", "PC", "PPC", "DP", "SP", "USP",
    "MAR", "IR", "MSW", "IPTR", "SHR", "HI", "LO", "C", "Z", "N", "V",
    string'({"SETFLAGS_", "WORD"}), string'({"SETFLAGS_", "HIBYTE"}),
    string'({"SETFLAGS_", "LOBYTE"}), "MEM",
    "LATCH_I", "LATCH_S", "FETCH", "CODE", "DATA", "SUPERVISOR"
  };
  string punct_set [14] = '{
    "<-", "++", "+", "--", "-", "&", "|", "^", "(", ")", ";", ",", "!", "*"
  };
  string dec_edges [3] = '{"0", "4294967295", "4294967296"};
  logic [7:0] blank_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

  dir_row_t directed_rows [N_DIR] = '{
    '{8'hFF, 1'b1, 1'b1, '{TOK_END, 32'd0, 16'd1, 12'd1, ERR_NONE, 1'b1}},
    '{"&",   1'b0, 1'b1, '{TOK_AND, 32'd0, 16'd1, 12'd1, ERR_NONE, 1'b1}},
    '{"|",   1'b0, 1'b1, '{TOK_OR,  32'd0, 16'd1, 12'd2, ERR_NONE, 1'b1}},
    '{"+",   1'b0, 1'b0, '0},
    '{"+",   1'b0, 1'b0, '0},
    '{"-",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{"<",   1'b0, 1'b0, '0},
    '{"-",   1'b0, 1'b0, '0},
    '{"$",   1'b0, 1'b0, '0},
    '{"f",   1'b0, 1'b0, '0},
    '{"(",   1'b0, 1'b0, '0},
    '{"p",   1'b0, 1'b0, '0},
    '{"c",   1'b0, 1'b0, '0},
    '{NL,    1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{NL,    1'b0, 1'b0, '0},
    '{"$",   1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{"a",   1'b0, 1'b0, '0},
    '{",",   1'b0, 1'b0, '0},
    '{"^",   1'b0, 1'b0, '0},
    '{")",   1'b0, 1'b0, '0},
    '{"!",   1'b0, 1'b0, '0},
    '{"*",   1'b0, 1'b0, '0},
    '{";",   1'b0, 1'b0, '0},
    '{8'h5A, 1'b1, 1'b0, '0}
  };

  // token model state
  mode_e       scan_st;
  logic [7:0]  name_buf [MAX_NAME];
  int          name_len;
  bit          name_long;
  logic [31:0] lit;
  bit          hex_seen;
  logic [15:0] line_ct;
  logic [11:0] col_ct;
  logic [11:0] tok_col;

  token_t      fresh_toks [$];
  token_t      expected_tokens [$];
  logic [7:0]  lex_bytes [$];
  lex_e        prev_kind;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          beats_sent;
  int          fails;
  int          cycle_ct;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (is_num(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit opens_token(logic [7:0] c);
    if (is_letter(c) || is_num(c) || is_blank(c)) return 1'b1;
    case (c)
      "/", "$", "<", "+", "-", "&", "|", "^", "(", ")", ";", ",", "!", "*": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [11:0] next_col();
    return (col_ct < COL_TOP) ? col_ct + 12'd1 : COL_TOP;
  endfunction

  function automatic int lookup_kw();
    string kw;
    int    i;
    int    j;
    bit    same;
    if (name_long) return -1;
    for (i = 0; i < KW_NUM; i++) begin
      kw = kw_names[i];
      if (kw.len() == name_len) begin
        same = 1'b1;
        for (j = 0; j < name_len; j++) begin
          if (name_buf[j] != kw[j]) same = 1'b0;
        end
        if (same) return i;
      end
    end
    return -1;
  endfunction

  task automatic add_tok(logic [TOKEN_W-1:0] code, logic [11:0] col, err_e err);
    fresh_toks.push_back('{code, lit, line_ct, col, err, 1'b0});
  endtask

  task automatic add_err(logic [11:0] col, err_e err);
    add_tok(TOK_ERROR, col, err);
    scan_st = MODE_HALT;
  endtask

  task automatic next_line();
    if (line_ct < LINE_TOP) line_ct++;
    col_ct = '0;
  endtask

  task automatic reset_model();
    scan_st   = MODE_IDLE;
    name_len  = 0;
    name_long = 1'b0;
    lit       = '0;
    hex_seen  = 1'b0;
    line_ct   = 16'd1;
    col_ct    = '0;
    tok_col   = '0;
  endtask

  task automatic start_token(logic [7:0] c, logic eof, logic [11:0] col);
    if (eof) begin
      add_tok(TOK_END, next_col(), ERR_NONE);
      return;
    end
    tok_col = col;
    if (c == NL) begin
      next_line();
    end else if (is_blank(c)) begin
    end else if (c == "/") begin
      scan_st = MODE_SLASH;
    end else if (is_letter(c)) begin
      name_buf[0] = (c >= "a") ? c - 8'd32 : c;
      name_len    = 1;
      name_long   = 1'b0;
      scan_st     = MODE_NAME;
    end else if (is_num(c)) begin
      lit     = {24'd0, c - 8'h30};
      scan_st = MODE_DEC;
    end else if (c == "$") begin
      hex_seen = 1'b0;
      scan_st  = MODE_HEX;
    end else begin
      case (c)
        "<": scan_st = MODE_LT;
        "+": scan_st = MODE_PLUS;
        "-": scan_st = MODE_MINUS;
        "&": add_tok(TOK_AND, col, ERR_NONE);
        "|": add_tok(TOK_OR, col, ERR_NONE);
        "^": add_tok(TOK_XOR, col, ERR_NONE);
        "(": add_tok(TOK_LPAREN, col, ERR_NONE);
        ")": add_tok(TOK_RPAREN, col, ERR_NONE);
        ";": add_tok(TOK_SEMI, col, ERR_NONE);
        ",": add_tok(TOK_COMMA, col, ERR_NONE);
        "!": add_tok(TOK_BANG, col, ERR_NONE);
        "*": add_tok(TOK_STAR, col, ERR_NONE);
        default: add_err(col, ERR_CHAR);
      endcase
    end
  endtask

  // tokens finished by one input beat land in fresh_toks
  task automatic tokenize(logic [7:0] c, logic eof);
    logic [11:0] col;
    bit          restart;
    int          hv;
    int          kw;
    logic [7:0]  dbl;
    token_t      tail;
    fresh_toks.delete();
    if (scan_st == MODE_HALT) return;
    col     = '0;
    restart = 1'b0;
    if (!eof) begin
      col    = next_col();
      col_ct = col;
    end
    case (scan_st)
      MODE_SLASH: begin
        if (!eof && c == "/") scan_st = MODE_COMMENT;
        else add_err(tok_col, ERR_COMMENT);
      end
      MODE_COMMENT: begin
        if (eof) begin
          add_tok(TOK_END, next_col(), ERR_NONE);
        end else if (c == NL) begin
          next_line();
          scan_st = MODE_IDLE;
        end
      end
      MODE_LT: begin
        if (!eof && c == "-") begin
          add_tok(TOK_XFER, tok_col, ERR_NONE);
          scan_st = MODE_IDLE;
        end else begin
          add_err(tok_col, ERR_CHAR);
        end
      end
      MODE_PLUS, MODE_MINUS: begin
        dbl = (scan_st == MODE_PLUS) ? "+" : "-";
        if (!eof && c == dbl) begin
          add_tok((scan_st == MODE_PLUS) ? TOK_INC : TOK_DECR, tok_col, ERR_NONE);
          scan_st = MODE_IDLE;
        end else begin
          add_tok((scan_st == MODE_PLUS) ? TOK_PLUS : TOK_MINUS, tok_col, ERR_NONE);
          restart = 1'b1;
        end
      end
      MODE_NAME: begin
        if (!eof && (is_letter(c) || c == "_")) begin
          if (name_len < MAX_NAME) begin
            name_buf[name_len] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            name_len++;
          end else begin
            name_long = 1'b1;
          end
        end else begin
          kw = lookup_kw();
          if (kw < 0) begin
            add_err(tok_col, ERR_NAME);
          end else begin
            add_tok(6'(kw), tok_col, ERR_NONE);
            restart = 1'b1;
          end
        end
      end
      MODE_DEC: begin
        if (!eof && is_num(c)) begin
          lit = lit * 32'd10 + {24'd0, c - 8'h30};
        end else begin
          add_tok(TOK_DECVAL, tok_col, ERR_NONE);
          restart = 1'b1;
        end
      end
      MODE_HEX: begin
        hv = eof ? -1 : hex_nibble(c);
        if (hv >= 0) begin
          lit      = hex_seen ? {lit[27:0], 4'(hv)} : 32'(hv);
          hex_seen = 1'b1;
        end else begin
          add_tok(TOK_HEXVAL, tok_col, ERR_NONE);
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      scan_st = MODE_IDLE;
      start_token(c, eof, col);
    end
    if (fresh_toks.size() > 0) begin
      tail      = fresh_toks.pop_back();
      tail.last = 1'b1;
      fresh_toks.push_back(tail);
    end
  endtask

  task automatic send_beat(logic [7:0] c, logic eof, logic typed, token_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.char_in <= c;
    in_bus.at_end  <= eof;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    tokenize(c, eof);
    if (typed) begin
      expected_tokens.push_back(want);
    end else begin
      foreach (fresh_toks[k]) expected_tokens.push_back(fresh_toks[k]);
    end
    beats_sent++;
  endtask

  task automatic send_lex_bytes(bit comment_eofs);
    int i;
    for (i = 0; i < lex_bytes.size(); i++) begin
      if (comment_eofs && i >= 2 && $urandom_range(99) < 8) begin
        send_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
      end
      send_beat(lex_bytes[i], 1'b0, 1'b0, '0);
    end
  endtask

  task automatic pause_until_drained();
    int waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (expected_tokens.size() > 0 && waited < DRAIN_LIMIT);
    if (expected_tokens.size() > 0) begin
      $error("tokens never delivered: %0d", expected_tokens.size());
      fails++;
      expected_tokens.delete();
    end
  endtask

  task automatic emit_lexeme();
    lex_e       kind;
    int         pick;
    int         n;
    int         i;
    int         v;
    string      txt;
    logic [7:0] b;
    bit         glue;
    lex_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 34)      kind = LX_NAME;
    else if (pick < 50) kind = LX_DEC;
    else if (pick < 62) kind = LX_HEX;
    else if (pick < 92) kind = LX_PUNCT;
    else                kind = LX_COMMENT;
    case (kind)
      LX_NAME: begin
        txt = kw_names[$urandom_range(KW_NUM-1)];
        for (i = 0; i < txt.len(); i++) begin
          b = txt[i];
          if (is_letter(b) && $urandom_range(1)) b = b + 8'd32;
          lex_bytes.push_back(b);
        end
      end
      LX_DEC: begin
        if ($urandom_range(9) == 0) begin
          txt = dec_edges[$urandom_range(2)];
          for (i = 0; i < txt.len(); i++) lex_bytes.push_back(txt[i]);
        end else begin
          n = $urandom_range(12, 1);
          for (i = 0; i < n; i++) lex_bytes.push_back(8'h30 + 8'($urandom_range(9)));
        end
      end
      LX_HEX: begin
        lex_bytes.push_back("$");
        n = ($urandom_range(9) == 0) ? 8 : $urandom_range(10);
        for (i = 0; i < n; i++) begin
          v = (n == 8 && $urandom_range(1)) ? 15 : $urandom_range(15);
          if (v < 10) b = 8'h30 + 8'(v);
          else b = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v - 10);
          lex_bytes.push_back(b);
        end
      end
      LX_PUNCT: begin
        txt = punct_set[$urandom_range(13)];
        for (i = 0; i < txt.len(); i++) lex_bytes.push_back(txt[i]);
      end
      default: begin
        lex_bytes.push_back("/");
        lex_bytes.push_back("/");
        n = $urandom_range(24);
        for (i = 0; i < n; i++) begin
          b = 8'($urandom_range(255));
          lex_bytes.push_back((b == NL) ? 8'h0B : b);
        end
        lex_bytes.push_back(NL);
      end
    endcase
    // a name or literal running into a letter or digit would merge
    glue = (prev_kind inside {LX_NAME, LX_DEC, LX_HEX}) &&
           (is_letter(lex_bytes[0]) || is_num(lex_bytes[0]));
    if (glue || $urandom_range(99) < 35) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) send_beat(blank_set[$urandom_range(5)], 1'b0, 1'b0, '0);
    end
    if ($urandom_range(99) < 5) send_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    send_lex_bytes(kind == LX_COMMENT);
    prev_kind = kind;
  endtask

  task automatic finish_with_error();
    int         n;
    int         i;
    logic [7:0] b;
    lex_bytes.delete();
    send_beat(" ", 1'b0, 1'b0, '0);
    case ($urandom_range(3))
      0: begin
        if ($urandom_range(1)) begin
          lex_bytes.push_back($urandom_range(1) ? "Q" : "q");
          n = $urandom_range(14);
          for (i = 0; i < n; i++) begin
            lex_bytes.push_back(($urandom_range(4) == 0) ? "_" : 8'h41 + 8'($urandom_range(25)));
          end
        end else begin
          n = $urandom_range(22, 16);
          for (i = 0; i < n; i++) lex_bytes.push_back(8'h61 + 8'($urandom_range(25)));
        end
        send_lex_bytes(1'b0);
        if ($urandom_range(1)) send_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
        else send_beat(" ", 1'b0, 1'b0, '0);
      end
      1: begin
        do b = 8'($urandom_range(255)); while (opens_token(b));
        send_beat(b, 1'b0, 1'b0, '0);
      end
      2: begin
        send_beat("<", 1'b0, 1'b0, '0);
        do b = 8'($urandom_range(255)); while (b == "-");
        send_beat(b, 1'($urandom_range(1)), 1'b0, '0);
      end
      default: begin
        send_beat("/", 1'b0, 1'b0, '0);
        do b = 8'($urandom_range(255)); while (b == "/");
        send_beat(b, 1'($urandom_range(1)), 1'b0, '0);
      end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_ct++;
    if (cycle_ct >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token beat: code %0d line %0d col %0d",
               out_bus.token_code, out_bus.line_number, out_bus.column_number);
        fails++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_bus.token_code !== want.code) begin
          $error("token_code: expected %0d, got %0d", want.code, out_bus.token_code);
          fails++;
        end
        if (out_bus.number_value !== want.value) begin
          $error("number_value: expected %0h, got %0h", want.value, out_bus.number_value);
          fails++;
        end
        if (out_bus.line_number !== want.line) begin
          $error("line_number: expected %0d, got %0d", want.line, out_bus.line_number);
          fails++;
        end
        if (out_bus.column_number !== want.col) begin
          $error("column_number: expected %0d, got %0d", want.col, out_bus.column_number);
          fails++;
        end
        if (out_bus.error_kind !== want.err) begin
          $error("error_kind: expected %0d, got %0d", want.err, out_bus.error_kind);
          fails++;
        end
        if (out_bus.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_bus.last_of_run);
          fails++;
        end
      end
    end
  end

  initial begin
    int i;
    int start;
    rst_ni          = 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.char_in <= '0;
    in_bus.at_end  <= 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    beats_sent      = 0;
    fails           = 0;
    cycle_ct        = 0;
    prev_kind       = LX_PUNCT;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIR; i++) begin
      send_beat(directed_rows[i].ch, directed_rows[i].eof, directed_rows[i].typed,
                directed_rows[i].want);
    end
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) emit_lexeme();

    // short operator tail with an end marker
    send_beat(NL, 1'b0, 1'b0, '0);
    send_beat("&", 1'b0, 1'b0, '0);
    send_beat("+", 1'b0, 1'b0, '0);
    send_beat("+", 1'b0, 1'b0, '0);
    send_beat(8'hA5, 1'b1, 1'b0, '0);
    send_beat(NL, 1'b0, 1'b0, '0);
    prev_kind = LX_PUNCT;
    pause_until_drained();

    send_idle_pct = 85;
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) emit_lexeme();
    pause_until_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 85;
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) emit_lexeme();
    pause_until_drained();

    send_idle_pct  = 30;
    recv_stall_pct = 30;
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) emit_lexeme();

    send_beat(NL, 1'b0, 1'b0, '0);
    send_beat("c", 1'b0, 1'b0, '0);
    send_beat(";", 1'b0, 1'b0, '0);
    send_beat(8'h3C, 1'b1, 1'b0, '0);
    send_beat(NL, 1'b0, 1'b0, '0);
    prev_kind = LX_PUNCT;
    pause_until_drained();

    finish_with_error();
    pause_until_drained();
    for (i = 0; i < 20; i++) begin
      send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
    end
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fails == 0 && expected_tokens.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
